// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tta_pkg.sv =====
// ----------------------------------------------------------------------------
// Tag allocator package
// Field widths and operation / status codes of the tag allocator.
// ----------------------------------------------------------------------------
package tta_pkg;

    localparam int TAG_W    = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC      = 2'd0,
        OP_ALLOC_IDLE = 2'd1,
        OP_LOOKUP     = 2'd2,
        OP_RELEASE    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_REFUSED   = 2'd2,
        ST_NOT_BUSY  = 2'd3
    } t_status;

endpackage

// ===== rtl/tta_req_if.sv =====
// ----------------------------------------------------------------------------
// Tag allocator request channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface tta_req_if;
    logic                      valid;
    logic                      ready;
    logic [tta_pkg::OP_W-1:0]  operation;
    logic [tta_pkg::TAG_W-1:0] tag;

    modport source (output valid, output operation, output tag, input ready);
    modport sink   (input valid, input operation, input tag, output ready);
endinterface

// ===== rtl/tta_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Tag allocator result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface tta_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tta_pkg::TAG_W-1:0]    tag_out;
    logic [tta_pkg::STATUS_W-1:0] status;
    logic                         pool_idle;

    modport source (output valid, output tag_out, output status, output pool_idle,
                    input ready);
    modport sink   (input valid, input tag_out, input status, input pool_idle,
                    output ready);
endinterface

// ===== rtl/transaction_tag_allocator_top.sv =====
// Result: a request item is held in the input register, and its result item in
//   the result register once the result side can take it.
// Throughput: one item per cycle while o_rsp.ready stays high; input register,
//   single-pass update of the free stack / busy bits, result register.
// Reset (i_rst_n low, synchronous): free stack reloaded with tag 1 on top,
//   all tags free, pipeline emptied.
// ----------------------------------------------------------------------------
// Transaction tag allocator
// LIFO free list of tags 1..SLOTS with per-tag busy bits; allocate,
// allocate-when-idle, lookup and release.
// ----------------------------------------------------------------------------
module transaction_tag_allocator_top #(
    parameter int SLOTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tta_req_if.sink       i_req,
    tta_rsp_if.source     o_rsp
);

`include "assert_macros.svh"

    localparam int TAG_W = tta_pkg::TAG_W;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS + 1);

    // input register
    logic                      r_in_valid;
    logic [tta_pkg::OP_W-1:0]  r_in_op;
    logic [TAG_W-1:0]          r_in_tag;

    // state; stack entry 0 is the top
    logic [TAG_W-1:0]          r_stack [SLOTS];
    logic [CNT_W-1:0]          r_count;
    logic [SLOTS:0]            r_busy;
    logic [TAG_W-1:0]          n_stack [SLOTS];
    logic [CNT_W-1:0]          n_count;
    logic [SLOTS:0]            n_busy;

    // result register
    logic                      r_out_valid;
    logic [TAG_W-1:0]          r_out_tag;
    tta_pkg::t_status          r_out_status;
    logic                      r_out_idle;

    logic                      adv;
    logic                      do_step;
    tta_pkg::t_op              op;
    logic                      in_range;
    logic                      tag_busy;
    logic                      pool_idle;
    logic [TAG_W-1:0]          res_tag;
    tta_pkg::t_status          res_status;

    assign adv         = !r_out_valid || o_rsp.ready;
    assign do_step     = r_in_valid && adv;
    assign i_req.ready = !r_in_valid || adv;

    assign op        = tta_pkg::t_op'(r_in_op);
    assign in_range  = (r_in_tag != '0) && (r_in_tag <= TAG_W'(SLOTS));
    assign tag_busy  = in_range && r_busy[r_in_tag[IDX_W-1:0]];
    assign pool_idle = (r_count == CNT_W'(SLOTS));

    always_comb begin
        n_stack    = r_stack;
        n_count    = r_count;
        n_busy     = r_busy;
        res_tag    = r_in_tag;
        res_status = tta_pkg::ST_OK;
        unique case (op)
            tta_pkg::OP_ALLOC, tta_pkg::OP_ALLOC_IDLE: begin
                res_tag = '0;
                if (op == tta_pkg::OP_ALLOC_IDLE && !pool_idle) begin
                    res_status = tta_pkg::ST_REFUSED;
                end else if (r_count == '0) begin
                    res_status = tta_pkg::ST_EXHAUSTED;
                end else begin
                    res_tag = r_stack[0];
                    n_busy[r_stack[0][IDX_W-1:0]] = 1'b1;
                    for (int k = 0; k < SLOTS - 1; k++) begin
                        n_stack[k] = r_stack[k+1];
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            tta_pkg::OP_LOOKUP: begin
                res_status = tag_busy ? tta_pkg::ST_OK : tta_pkg::ST_NOT_BUSY;
            end
            tta_pkg::OP_RELEASE: begin
                if (tag_busy) begin
                    n_busy[r_in_tag[IDX_W-1:0]] = 1'b0;
                    n_stack[0] = r_in_tag;
                    for (int k = 1; k < SLOTS; k++) begin
                        n_stack[k] = r_stack[k-1];
                    end
                    n_count = r_count + CNT_W'(1);
                end else begin
                    res_status = tta_pkg::ST_NOT_BUSY;
                end
            end
            default: begin
                res_status = tta_pkg::ST_NOT_BUSY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= CNT_W'(SLOTS);
            r_busy      <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_stack[k] <= TAG_W'(k + 1);
            end
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (do_step) begin
                r_out_valid <= 1'b1;
                r_stack     <= n_stack;
                r_count     <= n_count;
                r_busy      <= n_busy;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op  <= i_req.operation;
            r_in_tag <= i_req.tag;
        end
        if (do_step) begin
            r_out_tag    <= res_tag;
            r_out_status <= res_status;
            r_out_idle   <= (n_count == CNT_W'(SLOTS));
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.tag_out   = r_out_tag;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.pool_idle = r_out_idle;

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(SLOTS))
    `ASSERT_ALWAYS(a_busy_matches_count, i_clk, i_rst_n, $countones(r_busy) == int'(SLOTS) - int'(r_count))
    `ASSERT_NEXT(a_tag_zero_never_busy, i_clk, i_rst_n, 1'b1, !r_busy[0])

endmodule
